FILE: hw/rtl/dssl_pkg.sv
// dssl_pkg: shared types, constants and helper functions of the dual servo slew limiter
// no dependencies; used by dual_servo_slew_limiter
package dssl_pkg;

	// angle word width, 0.01 degree units
	localparam int unsigned AngW   = 15;
	localparam int unsigned RawW   = 16;
	localparam int unsigned DegW   = 8;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned ProdW  = 2 * AngW;
	localparam int unsigned DivCntW = 4;

	localparam logic [AngW-1:0] FullScale = AngW'(18000);
	localparam logic [AngW-1:0] HomeAngle = AngW'(9000);

	// register reset values
	localparam logic [AngW-1:0] RstLimMin    = AngW'(0);
	localparam logic [AngW-1:0] RstLimMax    = AngW'(18000);
	localparam logic [AngW-1:0] RstSmallDiff = AngW'(200);
	localparam logic [AngW-1:0] RstLargeDiff = AngW'(2000);
	localparam logic [AngW-1:0] RstSmallStep = AngW'(50);
	localparam logic [AngW-1:0] RstLargeStep = AngW'(300);

	// x / 100 as (x * 5243) >> 19, exact for x below 43690
	localparam int unsigned    RecipW     = 13;
	localparam logic [RecipW-1:0] Recip100 = RecipW'(5243);
	localparam int unsigned    RecipShift = 19;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_LIMIT_A_MIN = 3'd0,
		REG_LIMIT_A_MAX = 3'd1,
		REG_LIMIT_B_MIN = 3'd2,
		REG_LIMIT_B_MAX = 3'd3,
		REG_SMALL_DIFF  = 3'd4,
		REG_LARGE_DIFF  = 3'd5,
		REG_SMALL_STEP  = 3'd6,
		REG_LARGE_STEP  = 3'd7
	} cfg_reg_t;

	// input command codes
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIST,
		ST_MUL,
		ST_DIV,
		ST_APPLY,
		ST_OUT
	} state_t;

	// scale raw request by ten, clamp, mirror around full scale
	function automatic logic [AngW-1:0] make_target(
		input logic [RawW-1:0] raw,
		input logic [AngW-1:0] lo,
		input logic [AngW-1:0] hi
	);
		logic [RawW+3:0] scaled;
		logic [AngW-1:0] c;
		scaled = {1'b0, raw, 3'b000} + {3'b000, raw, 1'b0};
		if (scaled < {5'd0, lo})
			c = lo;
		else if (scaled > {5'd0, hi})
			c = hi;
		else
			c = scaled[AngW-1:0];
		if (c >= FullScale)
			make_target = '0;
		else
			make_target = FullScale - c;
	endfunction

	// whole degrees, truncated, low eight bits
	function automatic logic [DegW-1:0] to_deg(input logic [AngW-1:0] x);
		logic [AngW+RecipW-1:0] p;
		p = AngW'(x) * Recip100;
		to_deg = p[RecipShift +: DegW];
	endfunction

endpackage

FILE: hw/rtl/dual_servo_slew_limiter.sv
// dual_servo_slew_limiter: two-channel servo target load and slew limiting
// depends on dssl_pkg (types, constants, target and degree helpers)
// sequence: a load word sets both targets (LOAD, then OUT); a tick word steps channel A,
// then B, each through DIST and APPLY, with a multiply, then a 15-step shift-subtract
// divider shared by both channels, between them when its step is interpolated; one word
// at a time, the next taken once the last result is registered, later while m_tready is low
// reset: configuration registers to their documented values, targets and positions 90 degrees
module dual_servo_slew_limiter (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] angle_a_raw, [31:16] angle_b_raw
	input  logic        s_tuser,   // [0] command
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] position_a_deg, [15:8] position_b_deg
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	localparam int unsigned AW = dssl_pkg::AngW;

	dssl_pkg::state_t state_q, state_nxt;

	// configuration registers
	logic [AW-1:0] lim_a_min_q, lim_a_max_q, lim_b_min_q, lim_b_max_q;
	logic [AW-1:0] small_diff_q, large_diff_q, small_step_q, large_step_q;

	// channel state
	logic [AW-1:0] target_a_q, target_b_q, current_a_q, current_b_q;

	// work registers
	logic [dssl_pkg::RawW-1:0] raw_a_q, raw_b_q;
	logic                      ch_q;
	logic [AW-1:0]             dist_q, step_q, den_q, rem_q, quo_q;
	logic                      up_q, blend_q, neg_q;
	logic [dssl_pkg::DivCntW-1:0] div_cnt_q;
	logic                      out_valid_q;
	logic [15:0]               out_data_q;

	// control
	logic accept, out_free, div_last;
	logic dist_small, dist_large;

	// datapath signals
	logic [AW-1:0] cur_sel, tgt_sel, dist_now;
	logic [AW-1:0] step_mag, offset;
	logic [dssl_pkg::ProdW-1:0] prod;
	logic [AW:0]   div_sh, div_trial;
	logic          div_bit;
	logic [AW:0]   blended;
	logic [AW-1:0] step_use, cur_next;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_a_min_q  <= dssl_pkg::RstLimMin;
			lim_a_max_q  <= dssl_pkg::RstLimMax;
			lim_b_min_q  <= dssl_pkg::RstLimMin;
			lim_b_max_q  <= dssl_pkg::RstLimMax;
			small_diff_q <= dssl_pkg::RstSmallDiff;
			large_diff_q <= dssl_pkg::RstLargeDiff;
			small_step_q <= dssl_pkg::RstSmallStep;
			large_step_q <= dssl_pkg::RstLargeStep;
		end else if (cfg_we) begin
			unique case (dssl_pkg::cfg_reg_t'(cfg_index))
				dssl_pkg::REG_LIMIT_A_MIN: lim_a_min_q  <= cfg_data;
				dssl_pkg::REG_LIMIT_A_MAX: lim_a_max_q  <= cfg_data;
				dssl_pkg::REG_LIMIT_B_MIN: lim_b_min_q  <= cfg_data;
				dssl_pkg::REG_LIMIT_B_MAX: lim_b_max_q  <= cfg_data;
				dssl_pkg::REG_SMALL_DIFF:  small_diff_q <= cfg_data;
				dssl_pkg::REG_LARGE_DIFF:  large_diff_q <= cfg_data;
				dssl_pkg::REG_SMALL_STEP:  small_step_q <= cfg_data;
				dssl_pkg::REG_LARGE_STEP:  large_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// channel select and distance
	assign cur_sel    = ch_q ? current_b_q : current_a_q;
	assign tgt_sel    = ch_q ? target_b_q : target_a_q;
	assign dist_now   = (tgt_sel > cur_sel) ? tgt_sel - cur_sel : cur_sel - tgt_sel;
	assign dist_small = dist_now <= small_diff_q;
	assign dist_large = dist_now > large_diff_q;

	// blend numerator magnitude and sign
	assign step_mag = (large_step_q < small_step_q) ? small_step_q - large_step_q
	                                                : large_step_q - small_step_q;
	assign offset   = dist_q - small_diff_q;
	assign prod     = step_mag * offset;

	// one restoring divide step
	assign div_sh    = {rem_q, quo_q[AW-1]};
	assign div_trial = div_sh - {1'b0, den_q};
	assign div_bit   = div_sh >= {1'b0, den_q};
	assign div_last  = div_cnt_q == dssl_pkg::DivCntW'(AW - 1);

	// step and position update
	assign blended  = neg_q ? {1'b0, small_step_q} - {1'b0, quo_q}
	                        : {1'b0, small_step_q} + {1'b0, quo_q};
	assign step_use = blend_q ? blended[AW-1:0] : step_q;
	assign cur_next = (dist_q <= step_use) ? tgt_sel
	                : (up_q ? cur_sel + step_use : cur_sel - step_use);

	assign out_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dssl_pkg::ST_IDLE:
				if (s_tvalid)
					state_nxt = (dssl_pkg::cmd_t'(s_tuser) == dssl_pkg::CMD_LOAD)
					          ? dssl_pkg::ST_LOAD : dssl_pkg::ST_DIST;
			dssl_pkg::ST_LOAD:
				state_nxt = dssl_pkg::ST_OUT;
			dssl_pkg::ST_DIST:
				state_nxt = (dist_small || dist_large) ? dssl_pkg::ST_APPLY : dssl_pkg::ST_MUL;
			dssl_pkg::ST_MUL:
				state_nxt = dssl_pkg::ST_DIV;
			dssl_pkg::ST_DIV:
				if (div_last)
					state_nxt = dssl_pkg::ST_APPLY;
			dssl_pkg::ST_APPLY:
				state_nxt = ch_q ? dssl_pkg::ST_OUT : dssl_pkg::ST_DIST;
			dssl_pkg::ST_OUT:
				if (out_free)
					state_nxt = dssl_pkg::ST_IDLE;
			default:
				state_nxt = dssl_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = state_q == dssl_pkg::ST_IDLE;
		accept   = s_tready && s_tvalid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dssl_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// channel state and work registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_a_q  <= dssl_pkg::HomeAngle;
			target_b_q  <= dssl_pkg::HomeAngle;
			current_a_q <= dssl_pkg::HomeAngle;
			current_b_q <= dssl_pkg::HomeAngle;
			ch_q        <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			case (state_q)
				dssl_pkg::ST_LOAD: begin
					target_a_q <= dssl_pkg::make_target(raw_a_q, lim_a_min_q, lim_a_max_q);
					target_b_q <= dssl_pkg::make_target(raw_b_q, lim_b_min_q, lim_b_max_q);
				end
				dssl_pkg::ST_MUL:
					div_cnt_q <= '0;
				dssl_pkg::ST_DIV:
					div_cnt_q <= div_cnt_q + dssl_pkg::DivCntW'(1);
				dssl_pkg::ST_APPLY: begin
					if (ch_q)
						current_b_q <= cur_next;
					else
						current_a_q <= cur_next;
					ch_q <= !ch_q;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			raw_a_q <= s_tdata[15:0];
			raw_b_q <= s_tdata[31:16];
		end
		case (state_q)
			dssl_pkg::ST_DIST: begin
				dist_q  <= dist_now;
				up_q    <= tgt_sel > cur_sel;
				blend_q <= !(dist_small || dist_large);
				step_q  <= dist_small ? small_step_q : large_step_q;
			end
			dssl_pkg::ST_MUL: begin
				// quotient fits 15 bits, so the upper half seeds the remainder
				rem_q <= prod[dssl_pkg::ProdW-1:AW];
				quo_q <= prod[AW-1:0];
				den_q <= large_diff_q - small_diff_q;
				neg_q <= large_step_q < small_step_q;
			end
			dssl_pkg::ST_DIV: begin
				rem_q <= div_bit ? div_trial[AW-1:0] : div_sh[AW-1:0];
				quo_q <= {quo_q[AW-2:0], div_bit};
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == dssl_pkg::ST_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == dssl_pkg::ST_OUT && out_free)
			out_data_q <= {dssl_pkg::to_deg(current_b_q), dssl_pkg::to_deg(current_a_q)};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: test/dual_servo_slew_limiter_tb.sv
`timescale 1ns / 100ps
// dual_servo_slew_limiter_tb: self-checking bench for the two-channel servo slew limiter
// depends on dssl_pkg and dual_servo_slew_limiter; an in-bench model predicts every result word
module dual_servo_slew_limiter_tb;
	import dssl_pkg::*;

	typedef logic [AngW-1:0] angle_t;
	typedef logic [RawW-1:0] raw_t;

	// one result word, position_a_deg in the low byte
	typedef struct packed {
		logic [DegW-1:0] deg_b;
		logic [DegW-1:0] deg_a;
	} position_t;

	// register setting styles used by the random phases
	typedef enum {
		SET_TYPICAL,
		SET_ZERO,
		SET_FULL,
		SET_WIDE_BLEND,
		SET_SCRAMBLED
	} setting_kind_t;

	// predicts servo positions and checks result words in order
	class servo_scoreboard;
		angle_t    regs [8];
		angle_t    target_a, target_b, pos_a, pos_b;
		position_t expected_q [$];
		int        mismatches, checked, loads, ticks, settings;

		function new();
			regs[REG_LIMIT_A_MIN] = RstLimMin;
			regs[REG_LIMIT_A_MAX] = RstLimMax;
			regs[REG_LIMIT_B_MIN] = RstLimMin;
			regs[REG_LIMIT_B_MAX] = RstLimMax;
			regs[REG_SMALL_DIFF]  = RstSmallDiff;
			regs[REG_LARGE_DIFF]  = RstLargeDiff;
			regs[REG_SMALL_STEP]  = RstSmallStep;
			regs[REG_LARGE_STEP]  = RstLargeStep;
			target_a = HomeAngle;
			target_b = HomeAngle;
			pos_a = HomeAngle;
			pos_b = HomeAngle;
		endfunction

		// scale by ten, clamp to the channel window, mirror around 180 degrees
		function angle_t aim(raw_t raw, angle_t lo, angle_t hi);
			int unsigned scaled, c;
			scaled = raw * 10;
			if (scaled < lo)
				c = lo;
			else if (scaled > hi)
				c = hi;
			else
				c = scaled;
			if (c >= FullScale)
				return '0;
			return angle_t'(FullScale - c);
		endfunction

		// one control tick on one channel, step chosen by distance
		function angle_t slew(angle_t cur, angle_t tgt);
			longint gap, st, sd, ld, ss, ls;
			sd = regs[REG_SMALL_DIFF];
			ld = regs[REG_LARGE_DIFF];
			ss = regs[REG_SMALL_STEP];
			ls = regs[REG_LARGE_STEP];
			gap = (tgt > cur) ? tgt - cur : cur - tgt;
			if (gap <= sd)
				st = ss;
			else if (gap > ld)
				st = ls;
			else
				st = ss + (ls - ss) * (gap - sd) / (ld - sd);
			// snap when the target is within one step
			if (gap <= st)
				return tgt;
			return (tgt > cur) ? angle_t'(cur + st) : angle_t'(cur - st);
		endfunction

		function void note_word(cmd_t cmd, raw_t raw_a, raw_t raw_b);
			position_t want;
			if (cmd == CMD_LOAD) begin
				target_a = aim(raw_a, regs[REG_LIMIT_A_MIN], regs[REG_LIMIT_A_MAX]);
				target_b = aim(raw_b, regs[REG_LIMIT_B_MIN], regs[REG_LIMIT_B_MAX]);
				loads++;
			end else begin
				pos_a = slew(pos_a, target_a);
				pos_b = slew(pos_b, target_b);
				ticks++;
			end
			want.deg_a = DegW'(pos_a / 100);
			want.deg_b = DegW'(pos_b / 100);
			expected_q.push_back(want);
		endfunction

		function void check_word(logic [15:0] word);
			position_t got = word;
			position_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word a=%0d b=%0d", got.deg_a, got.deg_b);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.deg_a !== want.deg_a || got.deg_b !== want.deg_b) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: a exp %0d got %0d, b exp %0d got %0d",
						checked, want.deg_a, got.deg_a, want.deg_b, got.deg_b);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [15:0] angle_a_raw, [31:16] angle_b_raw
	logic        s_tuser = 1'b0; // [0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [7:0] position_a_deg, [15:8] position_b_deg
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;

	servo_scoreboard sb = new();
	angle_t          setting [8];
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;

	dual_servo_slew_limiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_word(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[31:16]);
		end
	end

	// present one word after a random gap and hold it until taken
	task automatic send_word(cmd_t cmd, raw_t raw_a, raw_t raw_b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {raw_b, raw_a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// hold off the sender until every expected word is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// write all eight registers from the current setting
	task automatic apply_config();
		cfg_reg_t r;
		r = r.first();
		do begin
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_data  <= setting[r];
			sb.regs[r] = setting[r];
			@(posedge clk);
			r = r.next();
		end while (r != r.first());
		cfg_we <= 1'b0;
		sb.settings++;
	endtask

	function automatic void make_setting(setting_kind_t kind);
		case (kind)
			SET_TYPICAL: begin
				setting[REG_LIMIT_A_MIN] = angle_t'($urandom_range(9000));
				setting[REG_LIMIT_A_MAX] = angle_t'($urandom_range(18000, 9000));
				setting[REG_LIMIT_B_MIN] = angle_t'($urandom_range(9000));
				setting[REG_LIMIT_B_MAX] = angle_t'($urandom_range(18000, 9000));
				setting[REG_SMALL_DIFF]  = angle_t'($urandom_range(2000));
				setting[REG_LARGE_DIFF]  = setting[REG_SMALL_DIFF] + angle_t'($urandom_range(6000, 1));
				setting[REG_SMALL_STEP]  = angle_t'($urandom_range(300));
				setting[REG_LARGE_STEP]  = setting[REG_SMALL_STEP] + angle_t'($urandom_range(3000));
			end
			SET_ZERO:
				foreach (setting[i]) setting[i] = '0;
			SET_FULL:
				foreach (setting[i]) setting[i] = '1;
			SET_WIDE_BLEND: begin
				setting[REG_LIMIT_A_MIN] = '0;
				setting[REG_LIMIT_A_MAX] = '1;
				setting[REG_LIMIT_B_MIN] = '0;
				setting[REG_LIMIT_B_MAX] = '1;
				setting[REG_SMALL_DIFF]  = '0;
				setting[REG_LARGE_DIFF]  = '1;
				setting[REG_SMALL_STEP]  = '0;
				setting[REG_LARGE_STEP]  = '1;
			end
			default:
				foreach (setting[i]) setting[i] = angle_t'($urandom);
		endcase
	endfunction

	// mostly in-range requests, some past 180 degrees, some full 16-bit
	function automatic raw_t pick_raw();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return raw_t'($urandom_range(1800));
			6:                return raw_t'($urandom_range(3276, 1801));
			7:                return $urandom_range(1) ? raw_t'('1) : raw_t'('0);
			default:          return raw_t'($urandom);
		endcase
	endfunction

	initial begin
		setting_kind_t plan [8];
		int n, burst;
		plan = '{SET_TYPICAL, SET_SCRAMBLED, SET_ZERO, SET_TYPICAL,
			SET_WIDE_BLEND, SET_SCRAMBLED, SET_FULL, SET_TYPICAL};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: idle tick, loads at both ends of the range, large steps
		send_word(CMD_TICK, '1, '0);
		send_word(CMD_LOAD, 16'd0, '1);
		repeat (4) send_word(CMD_TICK, '0, '1);
		send_word(CMD_LOAD, 16'd1800, 16'd900);
		send_word(CMD_LOAD, 16'd1799, 16'd1);
		repeat (2) send_word(CMD_TICK, raw_t'($urandom), raw_t'($urandom));
		drain();

		// inverted window on A, window past 180 degrees on B, unordered thresholds, zero small step
		setting[REG_LIMIT_A_MIN] = 15'd5000;
		setting[REG_LIMIT_A_MAX] = 15'd1000;
		setting[REG_LIMIT_B_MIN] = 15'd0;
		setting[REG_LIMIT_B_MAX] = 15'd32767;
		setting[REG_SMALL_DIFF]  = 15'd1000;
		setting[REG_LARGE_DIFF]  = 15'd500;
		setting[REG_SMALL_STEP]  = 15'd0;
		setting[REG_LARGE_STEP]  = 15'd400;
		apply_config();
		send_word(CMD_LOAD, 16'd300, 16'd2500);
		send_word(CMD_LOAD, 16'd600, 16'd1800);
		repeat (3) send_word(CMD_TICK, raw_t'($urandom), raw_t'($urandom));
		drain();

		// wide blend region with a big large step
		setting[REG_LIMIT_A_MIN] = 15'd0;
		setting[REG_LIMIT_A_MAX] = 15'd18000;
		setting[REG_LIMIT_B_MIN] = 15'd0;
		setting[REG_LIMIT_B_MAX] = 15'd18000;
		setting[REG_SMALL_DIFF]  = 15'd100;
		setting[REG_LARGE_DIFF]  = 15'd10000;
		setting[REG_SMALL_STEP]  = 15'd7;
		setting[REG_LARGE_STEP]  = 15'd9000;
		apply_config();
		send_word(CMD_LOAD, 16'd1000, 16'd0);
		repeat (5) send_word(CMD_TICK, raw_t'($urandom), raw_t'($urandom));
		drain();

		// random phases: a load followed by a burst of ticks, varied handshake pressure
		for (int p = 0; p < 8; p++) begin
			make_setting(plan[p]);
			apply_config();
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			n = 0;
			while (n < 210) begin
				send_word(CMD_LOAD, pick_raw(), pick_raw());
				n++;
				burst = $urandom_range(10);
				for (int k = 0; k < burst && n < 210; k++) begin
					send_word(CMD_TICK, raw_t'($urandom), raw_t'($urandom));
					n++;
				end
			end
			drain();
		end

		repeat (40) @(posedge clk);
		$display("covered %0d load words and %0d tick words over %0d register settings",
			sb.loads, sb.ticks, sb.settings);
		$display("and four handshake mixes; %0d result words checked, %0d mismatches",
			sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#8ms;
		$display("timeout with %0d result words outstanding", sb.expected_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/dssl_pkg.sv
hw/rtl/dual_servo_slew_limiter.sv
test/dual_servo_slew_limiter_tb.sv
